// ===== sv/gtfq_pkg.sv =====
// Shared types and constants for the grouped team FIFO queue.
package gtfq_pkg;

    localparam int TEAMS_DEF    = 1024;
    localparam int CAPACITY_DEF = 4096;
    localparam int MEMBER_W     = 20;
    localparam int TEAM_ID_W    = 10;
    localparam int MOD_SHIFT    = 20;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_DEQ   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_FULL  = 3'd3,
        ST_CLEAR = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_ENQ_MAP,
        S_ENQ,
        S_DEQ_ORD,
        S_DEQ_TEAM,
        S_DEQ_SLOT
    } state_t;

    // requests from the sequencer to the free slot allocator
    typedef struct packed {
        logic pop;
        logic push;
        logic clear;
    } free_ctl_t;

endpackage

// ===== sv/gtfq_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module gtfq_ram
    import gtfq_pkg::*;
#(
    parameter int DEPTH = TEAMS_DEF,
    parameter int WIDTH = MEMBER_W,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/gtfq_free_alloc.sv =====
// Free slot stack with fill count and low-water mark standing in for its reset image.
module gtfq_free_alloc
    import gtfq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int SW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  free_ctl_t     ctl,
    input  logic [SW-1:0] push_slot,
    output logic [SW-1:0] slot,
    output logic          empty
);

    logic [SW-1:0] stk [CAPACITY];
    logic [SW-1:0] top_q;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] low_reg;
    logic [CW-1:0] low_next;
    logic [CW-1:0] top_pos;
    logic          fresh;
    logic          push_we;

    assign top_pos = fill_reg - CW'(1);
    assign empty   = (fill_reg == '0);
    // positions below the low-water mark were never popped: they still hold their index
    assign fresh   = (fill_reg <= low_reg);
    assign slot    = fresh ? top_pos[SW-1:0] : top_q;
    assign push_we = ctl.push && (fill_reg < CW'(CAPACITY));

    always_comb
    begin
        fill_next = fill_reg;
        low_next  = low_reg;
        if (ctl.clear)
        begin
            fill_next = CW'(CAPACITY);
            low_next  = CW'(CAPACITY);
        end
        else if (ctl.pop)
        begin
            fill_next = top_pos;
            if (top_pos < low_reg)
            begin
                low_next = top_pos;
            end
        end
        else if (push_we)
        begin
            fill_next = fill_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= CW'(CAPACITY);
            low_reg  <= CW'(CAPACITY);
        end
        else
        begin
            fill_reg <= fill_next;
            low_reg  <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_we && !ctl.clear)
        begin
            stk[fill_reg[SW-1:0]] <= push_slot;
        end
        top_q <= stk[top_pos[SW-1:0]];
    end

endmodule

// ===== sv/gtfq_team_map.sv =====
// Reduces the incoming team id modulo TEAMS by reciprocal multiply, one product per cycle.
module gtfq_team_map
    import gtfq_pkg::*;
#(
    parameter int TEAMS = TEAMS_DEF,
    localparam int TW = $clog2(TEAMS)
)
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [TEAM_ID_W-1:0] team_id,
    output logic [TW-1:0]        team
);

    localparam int MW = MOD_SHIFT;
    localparam int RW = TEAM_ID_W + 3;
    localparam logic [MW-1:0] RECIP = MW'((2 ** MOD_SHIFT + TEAMS - 1) / TEAMS);

    logic [TEAM_ID_W-1:0]    id_reg;
    logic [TEAM_ID_W-1:0]    quo_reg;
    logic [TEAM_ID_W+MW-1:0] prod;
    logic [RW-1:0]           qt;
    logic [RW-1:0]           rem;

    // quotient is exact for every 10-bit id: id * (RECIP * TEAMS - 2^20) < 2^20
    assign prod = {{MW{1'b0}}, team_id} * {{TEAM_ID_W{1'b0}}, RECIP};
    assign qt   = RW'(quo_reg * TEAMS);
    assign rem  = {3'b000, id_reg} - qt;
    assign team = rem[TW-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg  <= team_id;
            quo_reg <= prod[MOD_SHIFT +: TEAM_ID_W];
        end
    end

endmodule

// ===== sv/grouped_team_fifo_queue.sv =====
// Top level of the grouped team FIFO queue: sequencer, team and slot memories, team ring.
//
//  channel   direction  ports                              handshake
//  command   in         operation, member_id, team_id      start, busy (taken on start & !busy)
//  result    out        status, member_out                 done (one cycle, no back-pressure)
//
// Enqueue runs from accept to next accept as: reduce the team id, read the team memory,
// then write back. Dequeue runs as: team ring read, team memory read, member and link
// read, then write-back. Empty results, and full results for an exhausted free stack,
// are decided at accept; a full team ring is found at the enqueue write-back. Results
// show on done the cycle after the final step. After reset and after a clear, busy stays
// high while the team memory is swept to zero; the clear answer comes out during that sweep.
module grouped_team_fifo_queue
    import gtfq_pkg::*;
#(
    parameter int TEAMS    = TEAMS_DEF,
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           operation,
    input  logic [MEMBER_W-1:0]  member_id,
    input  logic [TEAM_ID_W-1:0] team_id,
    output logic                 done,
    output logic [2:0]           status,
    output logic [MEMBER_W-1:0]  member_out
);

    localparam int TW  = $clog2(TEAMS);
    localparam int OW  = $clog2(TEAMS + 1);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int TMW = CW + 2 * SW;   // team word: {waiting, head, tail}

    state_t state_reg;
    state_t state_next;

    // control
    logic [TW-1:0] front_reg;
    logic [TW-1:0] front_next;
    logic [TW-1:0] back_reg;
    logic [TW-1:0] back_next;
    logic [OW-1:0] ofill_reg;
    logic [OW-1:0] ofill_next;
    logic [TW-1:0] sweep_reg;
    logic [TW-1:0] sweep_next;
    logic          done_reg;
    logic          done_next;

    // payload
    logic [MEMBER_W-1:0] member_reg;
    logic [MEMBER_W-1:0] member_next;
    logic [TW-1:0]       team_idx_reg;
    logic [TW-1:0]       team_idx_next;
    logic [SW-1:0]       slot_reg;
    logic [SW-1:0]       slot_next;
    logic [CW-1:0]       waiting_reg;
    logic [CW-1:0]       waiting_next;
    logic [SW-1:0]       tail_reg;
    logic [SW-1:0]       tail_next;
    status_t             status_reg;
    status_t             status_next;
    logic [MEMBER_W-1:0] mout_reg;
    logic [MEMBER_W-1:0] mout_next;

    // team memory
    logic           team_we;
    logic [TW-1:0]  team_waddr;
    logic [TMW-1:0] team_wdata;
    logic           team_re;
    logic [TW-1:0]  team_raddr;
    logic [TMW-1:0] team_q;
    logic [CW-1:0]  tq_waiting;
    logic [SW-1:0]  tq_head;
    logic [SW-1:0]  tq_tail;

    // team ring
    logic          order_we;
    logic          order_re;
    logic [TW-1:0] order_q;

    // member and link memories
    logic                member_we;
    logic                slot_re;
    logic [SW-1:0]       slot_raddr;
    logic [MEMBER_W-1:0] member_q;
    logic                link_we;
    logic [SW-1:0]       link_q;

    // helpers
    free_ctl_t     free_ctl;
    logic [SW-1:0] free_slot;
    logic          free_empty;
    logic          map_load;
    logic [TW-1:0] map_team;
    logic [CW-1:0] wait_dec;
    logic          accept;

    assign tq_waiting = team_q[TMW-1 -: CW];
    assign tq_head    = team_q[2*SW-1 -: SW];
    assign tq_tail    = team_q[SW-1:0];
    assign wait_dec   = (waiting_reg == '0) ? '0 : waiting_reg - CW'(1);

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign status     = status_reg;
    assign member_out = mout_reg;

    gtfq_team_map #(.TEAMS(TEAMS)) u_map (
        .clk     (clk),
        .load    (map_load),
        .team_id (team_id),
        .team    (map_team)
    );

    gtfq_free_alloc #(.CAPACITY(CAPACITY)) u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (free_ctl),
        .push_slot (slot_reg),
        .slot      (free_slot),
        .empty     (free_empty)
    );

    gtfq_ram #(.DEPTH(TEAMS), .WIDTH(TMW)) u_team_mem (
        .clk   (clk),
        .we    (team_we),
        .waddr (team_waddr),
        .wdata (team_wdata),
        .re    (team_re),
        .raddr (team_raddr),
        .rdata (team_q)
    );

    // ring of teams that have members waiting, in order of arrival
    gtfq_ram #(.DEPTH(TEAMS), .WIDTH(TW)) u_order_mem (
        .clk   (clk),
        .we    (order_we),
        .waddr (back_reg),
        .wdata (team_idx_reg),
        .re    (order_re),
        .raddr (front_reg),
        .rdata (order_q)
    );

    gtfq_ram #(.DEPTH(CAPACITY), .WIDTH(MEMBER_W)) u_member_mem (
        .clk   (clk),
        .we    (member_we),
        .waddr (free_slot),
        .wdata (member_reg),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (member_q)
    );

    // next slot of the same team; the tail's link is written when a member joins behind it
    gtfq_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_link_mem (
        .clk   (clk),
        .we    (link_we),
        .waddr (tq_tail),
        .wdata (free_slot),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (link_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        ofill_next    = ofill_reg;
        sweep_next    = sweep_reg;
        done_next     = 1'b0;
        member_next   = member_reg;
        team_idx_next = team_idx_reg;
        slot_next     = slot_reg;
        waiting_next  = waiting_reg;
        tail_next     = tail_reg;
        status_next   = status_reg;
        mout_next     = mout_reg;

        team_we    = 1'b0;
        team_waddr = team_idx_reg;
        team_wdata = '0;
        team_re    = 1'b0;
        team_raddr = team_idx_reg;
        order_we   = 1'b0;
        order_re   = 1'b0;
        member_we  = 1'b0;
        link_we    = 1'b0;
        slot_re    = 1'b0;
        slot_raddr = tq_head;
        free_ctl   = '0;
        map_load   = 1'b0;

        case (state_reg)
            S_SWEEP:
            begin
                // zero the waiting counts one team per cycle
                team_we    = 1'b1;
                team_waddr = sweep_reg;
                if (sweep_reg == TW'(TEAMS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + TW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(operation))
                        OP_ENQ:
                        begin
                            if (free_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                                mout_next   = '0;
                            end
                            else
                            begin
                                map_load    = 1'b1;
                                member_next = member_id;
                                state_next  = S_ENQ_MAP;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (ofill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                mout_next   = '0;
                            end
                            else
                            begin
                                order_re   = 1'b1;
                                state_next = S_DEQ_ORD;
                            end
                        end
                        OP_CLR:
                        begin
                            done_next      = 1'b1;
                            status_next    = ST_CLEAR;
                            mout_next      = '0;
                            free_ctl.clear = 1'b1;
                            front_next     = '0;
                            back_next      = '0;
                            ofill_next     = '0;
                            sweep_next     = '0;
                            state_next     = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ENQ_MAP:
            begin
                team_idx_next = map_team;
                team_re       = 1'b1;
                team_raddr    = map_team;
                state_next    = S_ENQ;
            end

            S_ENQ:
            begin
                done_next  = 1'b1;
                mout_next  = '0;
                state_next = S_IDLE;
                if ((tq_waiting == '0) && (ofill_reg >= OW'(TEAMS)))
                begin
                    // no room in the team ring: nothing changes
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next  = ST_ENQ;
                    free_ctl.pop = 1'b1;
                    member_we    = 1'b1;
                    team_we      = 1'b1;
                    if (tq_waiting == '0)
                    begin
                        // team was idle: it joins the back of the ring
                        team_wdata = {CW'(1), free_slot, free_slot};
                        order_we   = 1'b1;
                        back_next  = (back_reg == TW'(TEAMS - 1)) ? '0 : back_reg + TW'(1);
                        ofill_next = ofill_reg + OW'(1);
                    end
                    else
                    begin
                        team_wdata = {tq_waiting + CW'(1), tq_head, free_slot};
                        link_we    = 1'b1;
                    end
                end
            end

            S_DEQ_ORD:
            begin
                team_idx_next = order_q;
                team_re       = 1'b1;
                team_raddr    = order_q;
                state_next    = S_DEQ_TEAM;
            end

            S_DEQ_TEAM:
            begin
                slot_next    = tq_head;
                waiting_next = tq_waiting;
                tail_next    = tq_tail;
                slot_re      = 1'b1;
                slot_raddr   = tq_head;
                state_next   = S_DEQ_SLOT;
            end

            S_DEQ_SLOT:
            begin
                done_next     = 1'b1;
                status_next   = ST_DEQ;
                mout_next     = member_q;
                free_ctl.push = 1'b1;
                team_we       = 1'b1;
                team_wdata    = {wait_dec, link_q, tail_reg};
                if (wait_dec == '0)
                begin
                    // team emptied: drop it from the front of the ring
                    front_next = (front_reg == TW'(TEAMS - 1)) ? '0 : front_reg + TW'(1);
                    ofill_next = ofill_reg - OW'(1);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            ofill_reg <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            ofill_reg <= ofill_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        member_reg   <= member_next;
        team_idx_reg <= team_idx_next;
        slot_reg     <= slot_next;
        waiting_reg  <= waiting_next;
        tail_reg     <= tail_next;
        status_reg   <= status_next;
        mout_reg     <= mout_next;
    end

`ifndef NO_ASSERTIONS
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ofill_reg <= OW'(TEAMS))
        else $error("team ring count beyond TEAMS");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        free_ctl.pop |-> !free_empty)
        else $error("slot taken from an empty free stack");

    a_deq_has_team: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEQ_SLOT) |-> (ofill_reg != '0))
        else $error("dequeue completing with an empty team ring");

    a_deq_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_DEQ)) |-> $past(state_reg == S_DEQ_SLOT))
        else $error("dequeue result without a dequeue write-back");

    a_mout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_DEQ)) |-> (member_out == '0))
        else $error("member_out nonzero on a non-dequeue result");
`endif

endmodule
